// ===== src/sha256_byte_stream_hasher_assert.svh =====
// assertion macros for the hasher top level
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

`ifndef SYNTHESIS
`define SHBS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("shbs assertion failed");
`define SHBS_ASSERT_NEXT(lbl, clk, rst_n, cond, conseq) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("shbs assertion failed");
`else
`define SHBS_ASSERT(lbl, clk, rst_n, prop)
`define SHBS_ASSERT_NEXT(lbl, clk, rst_n, cond, conseq)
`endif

`endif

// ===== src/shbs_pkg.sv =====
// shared types, constants and tables for the sha-256 byte stream hasher
`timescale 1ns / 1ps

package shbs_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        REQ_ABSORB        = 2'd0,
        REQ_ABSORB_FINISH = 2'd1,
        REQ_FINISH        = 2'd2
    } t_req;

    typedef struct packed {
        logic       finish;
        logic       has_byte;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue_out;

    typedef struct packed {
        logic             valid;
        logic [7:0][31:0] words;
    } t_digest;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_ZERO,
        ST_LEN,
        ST_COMP,
        ST_ADD,
        ST_DONE
    } t_core_state;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    // word 0 sits in the lowest slot
    localparam logic [7:0][31:0] INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// ===== src/shbs_front.sv =====
// front end: takes requests, decodes them and queues commands for the core
`timescale 1ns / 1ps

module shbs_front #(
    parameter int DEPTH = shbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tvalid,
    output logic                 o_tready,
    input  logic [7:0]           i_tdata,
    input  logic [1:0]           i_tuser,
    output shbs_pkg::t_queue_out o_queue,
    input  logic                 i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    shbs_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    shbs_pkg::t_cmd w_cmd;
    logic           w_keep;
    logic           w_push;
    logic           w_pop;

    always_comb begin
        w_cmd.data     = i_tdata;
        w_cmd.has_byte = 1'b0;
        w_cmd.finish   = 1'b0;
        w_keep         = 1'b1;
        unique case (shbs_pkg::t_req'(i_tuser))
            shbs_pkg::REQ_ABSORB: begin
                w_cmd.has_byte = 1'b1;
            end
            shbs_pkg::REQ_ABSORB_FINISH: begin
                w_cmd.has_byte = 1'b1;
                w_cmd.finish   = 1'b1;
            end
            shbs_pkg::REQ_FINISH: begin
                w_cmd.finish = 1'b1;
            end
            // unused code is taken and dropped
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_tready = (r_count != CNT_W'(DEPTH));
    assign w_push   = i_tvalid && o_tready && w_keep;
    assign w_pop    = i_pop && (r_count != '0);

    assign o_queue.valid = (r_count != '0);
    assign o_queue.cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

// ===== src/shbs_core.sv =====
// back end: block buffer, padding, 64-round compression and chaining value
`timescale 1ns / 1ps

module shbs_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  shbs_pkg::t_queue_out i_queue,
    output logic                 o_pop,
    input  logic                 i_out_busy,
    output shbs_pkg::t_digest    o_digest
);

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    shbs_pkg::t_core_state r_state, n_state;
    shbs_pkg::t_core_state r_ret, n_ret;
    logic [5:0]            r_fill, n_fill;
    logic [60:0]           r_len, n_len;
    logic [63:0]           r_bits, n_bits;
    logic [5:0]            r_round, n_round;
    logic [7:0][31:0]      r_chain, n_chain;
    logic [7:0][31:0]      r_v, n_v;
    // message window: r_win[15] is the word used by the current round
    logic [15:0][31:0]     r_win, n_win;

    shbs_pkg::t_core_state w_after;
    logic                  w_put;
    logic [7:0]            w_byte;
    logic [31:0]           w_t1, w_t2, w_ch, w_maj, w_sched;

    always_comb begin
        w_ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        w_maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        w_t1    = r_v[7] + big_sigma1(r_v[4]) + w_ch + shbs_pkg::ROUND_K[r_round] + r_win[15];
        w_t2    = big_sigma0(r_v[0]) + w_maj;
        w_sched = small_sigma1(r_win[1]) + r_win[6] + small_sigma0(r_win[14]) + r_win[15];
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_fill   = r_fill;
        n_len    = r_len;
        n_bits   = r_bits;
        n_round  = r_round;
        n_chain  = r_chain;
        n_v      = r_chain;
        n_win    = r_win;
        w_after  = r_state;
        w_put    = 1'b0;
        w_byte   = '0;
        o_pop    = 1'b0;
        o_digest.valid = 1'b0;
        o_digest.words = r_chain;

        unique case (r_state)
            shbs_pkg::ST_IDLE: begin
                if (i_queue.valid) begin
                    o_pop = 1'b1;
                    if (i_queue.cmd.has_byte) begin
                        w_put  = 1'b1;
                        w_byte = i_queue.cmd.data;
                        n_len  = r_len + 61'd1;
                    end
                    w_after = i_queue.cmd.finish ? shbs_pkg::ST_MARK : shbs_pkg::ST_IDLE;
                end
            end
            shbs_pkg::ST_MARK: begin
                n_bits  = {r_len, 3'b000};
                w_put   = 1'b1;
                w_byte  = shbs_pkg::PAD_MARK;
                w_after = shbs_pkg::ST_ZERO;
            end
            shbs_pkg::ST_ZERO: begin
                if (r_fill == shbs_pkg::LEN_OFFSET) begin
                    w_after = shbs_pkg::ST_LEN;
                end else begin
                    w_put   = 1'b1;
                    w_after = shbs_pkg::ST_ZERO;
                end
            end
            shbs_pkg::ST_LEN: begin
                // length goes out most significant byte first
                w_put   = 1'b1;
                w_byte  = r_bits[63:56];
                n_bits  = {r_bits[55:0], 8'd0};
                w_after = shbs_pkg::ST_LEN;
                if (r_fill == 6'd63) begin
                    w_after = shbs_pkg::ST_DONE;
                end
            end
            shbs_pkg::ST_COMP: begin
                n_v[7]  = r_v[6];
                n_v[6]  = r_v[5];
                n_v[5]  = r_v[4];
                n_v[4]  = r_v[3] + w_t1;
                n_v[3]  = r_v[2];
                n_v[2]  = r_v[1];
                n_v[1]  = r_v[0];
                n_v[0]  = w_t1 + w_t2;
                n_win   = {r_win[14:0], w_sched};
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = shbs_pkg::ST_ADD;
                end
            end
            shbs_pkg::ST_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    n_chain[i] = r_chain[i] + r_v[i];
                end
                n_round = '0;
                n_state = r_ret;
            end
            shbs_pkg::ST_DONE: begin
                if (!i_out_busy) begin
                    o_digest.valid = 1'b1;
                    n_chain = shbs_pkg::INIT_HASH;
                    n_len   = '0;
                    n_fill  = '0;
                    n_state = shbs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = shbs_pkg::ST_IDLE;
            end
        endcase

        if (r_state == shbs_pkg::ST_IDLE || r_state == shbs_pkg::ST_MARK ||
            r_state == shbs_pkg::ST_ZERO || r_state == shbs_pkg::ST_LEN) begin
            n_state = w_after;
        end

        if (w_put) begin
            n_win  = {r_win[15][23:0], r_win[14:0], w_byte};
            n_fill = r_fill + 6'd1;
            // a full block diverts to compression and comes back afterwards
            if (r_fill == 6'd63) begin
                n_state = shbs_pkg::ST_COMP;
                n_ret   = w_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shbs_pkg::ST_IDLE;
            r_ret   <= shbs_pkg::ST_IDLE;
            r_fill  <= '0;
            r_len   <= '0;
            r_round <= '0;
            r_chain <= shbs_pkg::INIT_HASH;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fill  <= n_fill;
            r_len   <= n_len;
            r_round <= n_round;
            r_chain <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
        r_v    <= n_v;
        r_win  <= n_win;
    end

endmodule

// ===== src/shbs_out.sv =====
// digest output buffer: holds the eight words and streams them out in order
`timescale 1ns / 1ps

module shbs_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  shbs_pkg::t_digest i_digest,
    output logic              o_busy,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [31:0]       o_word,
    output logic [2:0]        o_index,
    output logic              o_last
);

    logic             r_busy, n_busy;
    logic [2:0]       r_idx, n_idx;
    logic [7:0][31:0] r_words, n_words;

    always_comb begin
        n_busy  = r_busy;
        n_idx   = r_idx;
        n_words = r_words;
        if (i_digest.valid) begin
            n_busy  = 1'b1;
            n_idx   = '0;
            n_words = i_digest.words;
        end else if (r_busy && i_tready) begin
            n_idx   = r_idx + 3'd1;
            n_words = {32'd0, r_words[7:1]};
            if (r_idx == 3'd7) begin
                n_busy = 1'b0;
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_tvalid = r_busy;
    assign o_word   = r_words[0];
    assign o_index  = r_idx;
    assign o_last   = (r_idx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_words <= n_words;
    end

endmodule

// ===== src/sha256_byte_stream_hasher.sv =====
// top level of the sha-256 byte stream hasher
// SHA-256 over a stream of byte requests. Each request on the slave side
// absorbs a byte, absorbs a byte and finishes, or finishes with no byte;
// the unused request code is taken and ignored. Requests land in a short
// command queue, so the input keeps accepting while the hash core works,
// until the queue is full. The core fills a 64-byte block and takes no new
// bytes while a full block goes through 64 compression rounds, one a cycle,
// and then the chaining update. A finish adds the padding and length bytes,
// a step before the length bytes and the digest handover, plus one or two
// further compressions; the eight digest words then sit in an output buffer
// and leave one per accepted cycle, word 0 first, with tlast on word 7. The
// core may start the next message while the previous digest is still
// draining, but waits at its own finish until the buffer is empty.
`timescale 1ns / 1ps
`include "sha256_byte_stream_hasher_assert.svh"

module sha256_byte_stream_hasher #(
    parameter int QUEUE_DEPTH = shbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_axis_tlast    // last_word
);

    shbs_pkg::t_queue_out w_queue;
    shbs_pkg::t_digest    w_digest;
    logic                 w_pop;
    logic                 w_out_busy;
    logic [31:0]          w_word;
    logic [2:0]           w_index;

    shbs_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .o_queue  (w_queue),
        .i_pop    (w_pop)
    );

    shbs_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_queue    (w_queue),
        .o_pop      (w_pop),
        .i_out_busy (w_out_busy),
        .o_digest   (w_digest)
    );

    shbs_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_digest (w_digest),
        .o_busy   (w_out_busy),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_word   (w_word),
        .o_index  (w_index),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, w_index, w_word};

    // a digest is only handed over into an empty output buffer
    `SHBS_ASSERT(a_handoff_empty, i_clk, i_rst_n, w_digest.valid |-> !w_out_busy)
    // a fresh digest starts at word 0
    `SHBS_ASSERT_NEXT(a_handoff_first, i_clk, i_rst_n, w_digest.valid, m_axis_tvalid && (m_axis_tdata[34:32] == 3'd0))
    // after the last word the buffer drains fully
    `SHBS_ASSERT_NEXT(a_last_drains, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid)
    // the queue is never popped while empty
    `SHBS_ASSERT(a_pop_nonempty, i_clk, i_rst_n, w_pop |-> w_queue.valid)

endmodule
